@@ hdl/tccw_pkg.sv @@
// Package: shared constants, field widths, sequencer states and result type.
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE   = 8'd10;
    localparam logic [CHAR_W-1:0]  BLANK_CODE     = 8'd32;
    localparam logic [COLOR_W-1:0] BLANK_ATTR_RST = 8'd7;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              scrolled;
        logic [COL_W-1:0]  col_now;
        logic [ROW_W-1:0]  row_now;
        logic [CELL_W-1:0] cell_value;
    } result_t;

endpackage

@@ hdl/text_console_char_writer.sv @@
// Top level: text console writer with stream ports and blank attribute register.
`timescale 1ns / 1ps

// Text console character writer. The screen is a store of ROWS x COLUMNS
// 16-bit cells (color byte high, character byte low) in one synchronous RAM,
// with a cursor in flip-flops. A put transaction (tuser 0) writes its
// character at the cursor and advances it, or for a newline moves to column
// 0 of the next row; a read transaction (tuser 1) returns one cell, 0 when the
// row or column lies off screen. Each transaction gives exactly one result.
// A put goes from acceptance to the DONE state, and from there its result
// enters the output register; a read first passes the READ state, where the
// registered RAM output is taken. A put that runs off the bottom row
// scrolls the screen: the sequencer copies each cell one row up through
// the single RAM read port, one cell a cycle, then fills the bottom row
// with blanks in the blank attribute last written on cfg_wr_data.
// After reset the RAM is swept to zero; s_tready stays low until the sweep
// ends, and cfg_wr_en is taken at any time. One transaction
// is in work at a time; a finished result sits in the output register so
// the next transaction may be accepted while m_tready is low.
module text_console_char_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: attribute byte of scroll blanks
    input  logic                               cfg_wr_en,
    input  logic [tccw_pkg::COLOR_W-1:0]       cfg_wr_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // char_code[7:0], color[15:8], read_row[20:16], read_col[27:21], zero fill
    input  logic [tccw_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[0]
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_value[15:0], cursor_row_now[20:16], cursor_col_now[27:21],
    // scrolled[28], zero fill
    output logic [tccw_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [tccw_pkg::COLOR_W-1:0]   blank_attr_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tccw_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic              done_valid;
    logic              done_ready;
    logic              out_load;
    tccw_pkg::result_t result;

    // hold the attribute used for scroll blanks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_attr_reg <= tccw_pkg::BLANK_ATTR_RST;
        end else if (cfg_wr_en) begin
            blank_attr_reg <= cfg_wr_data;
        end
    end

    // output register is free when empty or being drained this cycle
    assign done_ready = !m_tvalid_reg || m_tready;
    assign out_load   = done_valid && done_ready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= tccw_pkg::M_TDATA_W'(result);
        end
    end

    tccw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .func        (s_tuser),
        .char_code   (s_tdata[7:0]),
        .color       (s_tdata[15:8]),
        .read_row    (s_tdata[20:16]),
        .read_col    (s_tdata[27:21]),
        .blank_color (blank_attr_reg),
        .done_valid  (done_valid),
        .done_ready  (done_ready),
        .result      (result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/tccw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tccw_seq.sv @@
// Sequencer: cursor, cell store and the clear, scroll and fill sweeps.
`timescale 1ns / 1ps

module tccw_seq #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [tccw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tccw_pkg::COLOR_W-1:0] color,
    input  logic [tccw_pkg::ROW_W-1:0]   read_row,
    input  logic [tccw_pkg::COL_W-1:0]   read_col,
    input  logic [tccw_pkg::COLOR_W-1:0] blank_color,
    output logic                         done_valid,
    input  logic                         done_ready,
    output tccw_pkg::result_t            result
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

    tccw_pkg::state_t state_reg, state_next;

    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          rd_hit_reg, rd_hit_next;
    logic [tccw_pkg::CELL_W-1:0] res_cell_reg, res_cell_next;
    logic          scrolled_reg, scrolled_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tccw_pkg::CELL_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tccw_pkg::CELL_W-1:0] ram_rdata;

    logic          accept;
    logic          is_newline;
    logic          col_last;
    logic          row_adv;
    logic [RW:0]   row_inc;
    logic          put_scroll;
    logic          sweep_end;

    assign accept     = in_valid && (state_reg == tccw_pkg::ST_IDLE);
    assign is_newline = (char_code == tccw_pkg::NEWLINE_CODE);
    assign col_last   = (cur_col_reg == LAST_COL);
    assign row_adv    = is_newline || col_last;
    assign row_inc    = {1'b0, cur_row_reg} + (RW + 1)'(1);
    assign put_scroll = row_adv && (row_inc == (RW + 1)'(ROWS));
    assign sweep_end  = (row_reg == LAST_ROW) && (col_reg == LAST_COL);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                if (sweep_end) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (func == tccw_pkg::FUNC_READ) begin
                        state_next = tccw_pkg::ST_READ;
                    end else if (put_scroll) begin
                        state_next = tccw_pkg::ST_SCROLL;
                    end else begin
                        state_next = tccw_pkg::ST_DONE;
                    end
                end
            end
            tccw_pkg::ST_READ: begin
                state_next = tccw_pkg::ST_DONE;
            end
            tccw_pkg::ST_SCROLL: begin
                if (sweep_end) begin
                    state_next = tccw_pkg::ST_FILL;
                end
            end
            tccw_pkg::ST_FILL: begin
                if (!pend_reg && (col_reg == LAST_COL)) begin
                    state_next = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_DONE: begin
                if (done_ready) begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default: state_next = tccw_pkg::ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        rd_hit_next    = rd_hit_reg;
        res_cell_next  = res_cell_reg;
        scrolled_next  = scrolled_reg;
        ram_we         = 1'b0;
        ram_waddr      = {row_reg, col_reg};
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = {row_reg, col_reg};

        case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (col_reg == LAST_COL) begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (accept) begin
                    res_cell_next = '0;
                    scrolled_next = 1'b0;
                    if (func == tccw_pkg::FUNC_READ) begin
                        ram_re      = 1'b1;
                        ram_raddr   = {read_row[RW-1:0], read_col[CW-1:0]};
                        rd_hit_next = ({1'b0, read_row} < (tccw_pkg::ROW_W + 1)'(ROWS)) &&
                                      ({1'b0, read_col} < (tccw_pkg::COL_W + 1)'(COLUMNS));
                    end else begin
                        if (!is_newline) begin
                            ram_we    = 1'b1;
                            ram_waddr = {cur_row_reg, cur_col_reg};
                            ram_wdata = {color, char_code};
                        end
                        if (row_adv) begin
                            cur_col_next = '0;
                            cur_row_next = put_scroll ? LAST_ROW : row_inc[RW-1:0];
                        end else begin
                            cur_col_next = cur_col_reg + CW'(1);
                        end
                        if (put_scroll) begin
                            scrolled_next = 1'b1;
                            row_next      = RW'(1);
                            col_next      = '0;
                        end
                    end
                end
            end
            tccw_pkg::ST_READ: begin
                res_cell_next = rd_hit_reg ? ram_rdata : '0;
            end
            tccw_pkg::ST_SCROLL: begin
                // read the source cell, write it one row up next cycle
                ram_re         = 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = {row_reg - RW'(1), col_reg};
                if (col_reg == LAST_COL) begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            tccw_pkg::ST_FILL: begin
                if (!pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = {LAST_ROW, col_reg};
                    ram_wdata = {blank_color, tccw_pkg::BLANK_CODE};
                    col_next  = (col_reg == LAST_COL) ? '0 : col_reg + CW'(1);
                end
            end
            tccw_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase

        // drain the copy still in flight from the scroll sweep
        if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tccw_pkg::ST_CLEAR;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            pend_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            pend_reg     <= pend_next;
            scrolled_reg <= scrolled_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        rd_hit_reg    <= rd_hit_next;
        res_cell_reg  <= res_cell_next;
    end

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == tccw_pkg::ST_IDLE);
    assign done_valid = (state_reg == tccw_pkg::ST_DONE);

    assign result.cell_value = res_cell_reg;
    assign result.row_now    = tccw_pkg::ROW_W'(cur_row_reg);
    assign result.col_now    = tccw_pkg::COL_W'(cur_col_reg);
    assign result.scrolled   = scrolled_reg;

endmodule

@@ hdl/tccw_checker.sv @@
// Port checker for the text console writer, bound to the top level.
`timescale 1ns / 1ps

module tccw_checker #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tccw_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // cursor stays on screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[20:16]) < ROWS) && (32'(m_tdata[27:21]) < COLUMNS))
        else $error("cursor off screen");

    // a scroll leaves the cursor on the last row and carries no cell
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |->
            (32'(m_tdata[20:16]) == ROWS - 1) && (m_tdata[15:0] == 16'd0))
        else $error("bad scroll result");

endmodule

bind text_console_char_writer tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_text_console_char_writer.sv @@
// Testbench for the text console character writer: stream driver, monitor and cell-store predictor.
`timescale 1ns / 1ps

// The testbench drives put and read transactions into the console writer and
// checks every result against its own model of the screen store and cursor.
//
// Flow:
//   - An initial block fills a queue of pending commands, phase by phase.
//     Between phases it lets the block drain completely, then rewrites
//     the blank attribute. The drain also makes the sender pause until every
//     expected result has arrived.
//   - The driver pulls commands from that queue and presents them on the
//     s_ channel, with a random gap before each new one.
//   - The driver runs the screen model when the s_ channel accepts a
//     transaction and pushes the predicted result.
//   - The monitor takes results from the m_ channel, with random back-pressure,
//     and compares each one field by field with the oldest prediction.
//
// The stimulus has a short directed opening. It reads the cleared screen,
// including off-screen rows and columns, and puts the extreme character and
// color bytes. The rest is random sequences:
//   - text lines, some long enough to wrap at the last column;
//   - runs of newlines, which push the cursor to the bottom row and scroll;
//   - bursts of cell reads;
//   - some fully random noise.
module tb_text_console_char_writer;

    localparam int COLUMNS   = tccw_pkg::COLUMNS_DEF;
    localparam int ROWS      = tccw_pkg::ROWS_DEF;
    localparam int CHAR_W    = tccw_pkg::CHAR_W;
    localparam int COLOR_W   = tccw_pkg::COLOR_W;
    localparam int CELL_W    = tccw_pkg::CELL_W;
    localparam int ROW_W     = tccw_pkg::ROW_W;
    localparam int COL_W     = tccw_pkg::COL_W;
    localparam int S_TDATA_W = tccw_pkg::S_TDATA_W;
    localparam int M_TDATA_W = tccw_pkg::M_TDATA_W;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE   = tccw_pkg::NEWLINE_CODE;
    localparam logic [CHAR_W-1:0]  BLANK_CODE     = tccw_pkg::BLANK_CODE;
    localparam logic [COLOR_W-1:0] BLANK_ATTR_RST = tccw_pkg::BLANK_ATTR_RST;
    localparam logic               FUNC_PUT       = tccw_pkg::FUNC_PUT;
    localparam logic               FUNC_READ      = tccw_pkg::FUNC_READ;

    // The random part adds whole sequences until a phase holds this many
    // transactions; five phases give about 400 transactions in total.
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int unsigned PHASES      = 5;

    // Slowest correct transaction: a put that scrolls, plus the longest
    // sender gap and the longest receiver stall.
    localparam int unsigned WORST_ITEM_CYCLES = ROWS * COLUMNS + 3 + 2 * 19 + 4;
    // Allow for some overshoot of the phase size, take it four times over,
    // and add the clearing sweep after reset.
    localparam int unsigned CYCLE_LIMIT =
        4 * (PHASES * PHASE_ITEMS + 200) * WORST_ITEM_CYCLES + 2 * ROWS * COLUMNS;
    // Cycles to let pass once nothing is expected any more.
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        logic               func;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
    } console_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row_now;
        logic [COL_W-1:0]  cursor_col_now;
        logic              scrolled;
    } console_resp_t;

    localparam int CMD_W = $bits(console_cmd_t);

    // ------------------------------------------------------------------
    // Clock, reset and ports
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_wr_en   = 1'b0;
    logic [COLOR_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    always #5 aclk = ~aclk;

    text_console_char_writer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // ------------------------------------------------------------------
    // Screen model: cell store, cursor and blank attribute
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  screen_mem [ROWS][COLUMNS];
    int                 model_row;
    int                 model_col;
    logic [COLOR_W-1:0] blank_color;

    console_cmd_t  pending_cmds [$];
    console_resp_t expected_resps [$];

    int unsigned queued_total = 0;
    int unsigned recv_total   = 0;
    int unsigned err_count    = 0;
    int unsigned n_puts       = 0;
    int unsigned n_reads      = 0;
    int unsigned n_scrolls    = 0;
    int unsigned n_wraps      = 0;
    int unsigned n_off_reads  = 0;
    int unsigned cycle_count  = 0;

    // Apply one accepted transaction to the screen model and return its result.
    function automatic console_resp_t console_apply(console_cmd_t cmd);
        console_resp_t resp;
        resp = '0;
        if (cmd.func == FUNC_READ) begin
            n_reads++;
            // Off-screen coordinates read back as zero.
            if (cmd.read_row < ROWS && cmd.read_col < COLUMNS)
                resp.cell_value = screen_mem[cmd.read_row][cmd.read_col];
            else
                n_off_reads++;
        end else begin
            n_puts++;
            if (cmd.char_code == NEWLINE_CODE) begin
                model_row++;
                model_col = 0;
            end else begin
                screen_mem[model_row][model_col] = {cmd.color, cmd.char_code};
                model_col++;
                // Wrap to the start of the next row after the last column.
                if (model_col >= COLUMNS) begin
                    model_col = 0;
                    model_row++;
                    n_wraps++;
                end
            end
            // Off the bottom: move every row up one, blank the last row.
            if (model_row >= ROWS) begin
                for (int r = 0; r < ROWS - 1; r++)
                    screen_mem[r] = screen_mem[r + 1];
                for (int c = 0; c < COLUMNS; c++)
                    screen_mem[ROWS - 1][c] = {blank_color, BLANK_CODE};
                model_row = ROWS - 1;
                resp.scrolled = 1'b1;
                n_scrolls++;
            end
        end
        resp.cursor_row_now = model_row[ROW_W-1:0];
        resp.cursor_col_now = model_col[COL_W-1:0];
        return resp;
    endfunction

    // Draw a random idle count; now and then flip into or out of a
    // quiet stretch where nothing idles.
    function automatic int unsigned draw_wait(inout bit quiet);
        if ($urandom_range(0, 29) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Unused fields get random values, which the block must ignore.
    task automatic queue_put(int unsigned code, int unsigned color);
        console_cmd_t cmd;
        cmd.func      = FUNC_PUT;
        cmd.char_code = CHAR_W'(code);
        cmd.color     = COLOR_W'(color);
        cmd.read_row  = ROW_W'($urandom_range(0, 31));
        cmd.read_col  = COL_W'($urandom_range(0, 127));
        pending_cmds.push_back(cmd);
        queued_total++;
    endtask

    task automatic queue_read(int unsigned row, int unsigned col);
        console_cmd_t cmd;
        cmd.func      = FUNC_READ;
        cmd.char_code = CHAR_W'($urandom_range(0, 255));
        cmd.color     = COLOR_W'($urandom_range(0, 255));
        cmd.read_row  = ROW_W'(row);
        cmd.read_col  = COL_W'(col);
        pending_cmds.push_back(cmd);
        queued_total++;
    endtask

    // Queue one random sequence: a text line, a newline run, a read burst or
    // noise. Long lines cross the last column so the cursor wraps.
    task automatic queue_random_sequence();
        int unsigned  kind;
        int unsigned  len;
        int unsigned  code;
        int unsigned  line_color;
        console_cmd_t cmd;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(COLUMNS - 4, COLUMNS + 4)
                                              : $urandom_range(0, 10);
            line_color = $urandom_range(0, 255);
            for (int unsigned i = 0; i < len; i++) begin
                code = $urandom_range(0, 255);
                if (code == 32'(NEWLINE_CODE))
                    code = 32'(BLANK_CODE);
                queue_put(code, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                            : line_color);
            end
            if ($urandom_range(0, 4) != 0)
                queue_put(32'(NEWLINE_CODE), $urandom_range(0, 255));
        end else if (kind < 70) begin
            len = $urandom_range(1, 8);
            for (int unsigned i = 0; i < len; i++)
                queue_put(32'(NEWLINE_CODE), $urandom_range(0, 255));
        end else if (kind < 90) begin
            len = $urandom_range(1, 4);
            for (int unsigned i = 0; i < len; i++) begin
                if ($urandom_range(0, 6) == 0)
                    queue_read($urandom_range(0, 31), $urandom_range(0, 127));
                else if ($urandom_range(0, 3) == 0)
                    queue_read(ROWS - 1, $urandom_range(0, COLUMNS - 1));
                else
                    queue_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
            end
        end else begin
            len = $urandom_range(1, 3);
            for (int unsigned i = 0; i < len; i++) begin
                cmd = console_cmd_t'(CMD_W'($urandom));
                pending_cmds.push_back(cmd);
                queued_total++;
            end
        end
    endtask

    task automatic queue_random_phase(int unsigned count);
        int unsigned start;
        start = queued_total;
        while (queued_total - start < count)
            queue_random_sequence();
    endtask

    // Hold until a result has come back for every queued command, then let
    // the block settle.
    task automatic wait_drained();
        while (recv_total != queued_total)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the blank attribute while the block is idle and track it in the model.
    task automatic write_blank_color(logic [COLOR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        blank_color = value;
    endtask

    // ------------------------------------------------------------------
    // Driver: present pending commands on the s_ channel
    // ------------------------------------------------------------------
    console_cmd_t in_flight;
    int unsigned  send_wait  = 0;
    bit           send_quiet = 1'b0;

    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            send_wait <= 0;
        end else begin
            next_valid = s_tvalid;
            // Predict the result of each transaction as it is accepted.
            if (s_tvalid && s_tready) begin
                expected_resps.push_back(console_apply(in_flight));
                next_valid = 1'b0;
            end
            // Hold the current command until it is taken; otherwise wait out
            // the gap and then load the next one.
            if (!next_valid) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                end else if (pending_cmds.size() != 0) begin
                    in_flight  = pending_cmds.pop_front();
                    s_tdata   <= {4'b0, in_flight.read_col, in_flight.read_row,
                                  in_flight.color, in_flight.char_code};
                    s_tuser   <= in_flight.func;
                    send_wait <= draw_wait(send_quiet);
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: accept results on the m_ channel and compare
    // ------------------------------------------------------------------
    int unsigned recv_wait  = 0;
    bit          recv_quiet = 1'b0;

    always @(posedge aclk) begin
        console_resp_t got;
        console_resp_t want;
        int unsigned   stall;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            stall = recv_wait;
            if (m_tvalid && m_tready) begin
                recv_total++;
                got.cell_value     = m_tdata[15:0];
                got.cursor_row_now = m_tdata[20:16];
                got.cursor_col_now = m_tdata[27:21];
                got.scrolled       = m_tdata[28];
                if (expected_resps.size() == 0) begin
                    $error("result transaction with no prediction pending: tdata %h", m_tdata);
                    err_count++;
                end else begin
                    want = expected_resps.pop_front();
                    if (got.cell_value !== want.cell_value) begin
                        $error("cell_value: expected %h, got %h",
                               want.cell_value, got.cell_value);
                        err_count++;
                    end
                    if (got.cursor_row_now !== want.cursor_row_now) begin
                        $error("cursor_row_now: expected %0d, got %0d",
                               want.cursor_row_now, got.cursor_row_now);
                        err_count++;
                    end
                    if (got.cursor_col_now !== want.cursor_col_now) begin
                        $error("cursor_col_now: expected %0d, got %0d",
                               want.cursor_col_now, got.cursor_col_now);
                        err_count++;
                    end
                    if (got.scrolled !== want.scrolled) begin
                        $error("scrolled: expected %0d, got %0d",
                               want.scrolled, got.scrolled);
                        err_count++;
                    end
                end
                // Draw the stall before the next result.
                stall = draw_wait(recv_quiet);
            end else if (stall != 0) begin
                stall--;
            end
            recv_wait <= stall;
            m_tready  <= (stall == 0);
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        logic [COLOR_W-1:0] phase_color;

        // Model state after reset: screen cleared, cursor home, color 7.
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
                screen_mem[r][c] = '0;
        model_row   = 0;
        model_col   = 0;
        blank_color = BLANK_ATTR_RST;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: the cleared screen, including off-screen corners.
        queue_read(0, 0);
        queue_read(ROWS - 1, COLUMNS - 1);
        queue_read(ROWS, 0);
        queue_read(0, COLUMNS);
        queue_read(31, 127);
        // Extreme character and color bytes, and bytes with the top bit set.
        queue_put('h00, 'h00);
        queue_put('hFF, 'hFF);
        queue_put('h80, 'h5A);
        queue_put('h41, 'hA5);
        queue_put(32'(NEWLINE_CODE), 'hFF);
        queue_put('h09, 'h1E);
        queue_put(32'(BLANK_CODE), 'h7F);
        // Read back what was written, on both rows.
        queue_read(0, 0);
        queue_read(0, 1);
        queue_read(0, 2);
        queue_read(0, 3);
        queue_read(0, 4);
        queue_read(1, 0);
        queue_read(1, 1);
        queue_read(1, 2);
        queue_random_phase(PHASE_ITEMS - queued_total);

        // Later phases: drain, change the blank attribute, continue the text.
        for (int p = 1; p < PHASES; p++) begin
            wait_drained();
            case (p)
                1:       phase_color = 8'h00;
                2:       phase_color = 8'hFF;
                default: phase_color = COLOR_W'($urandom_range(1, 254));
            endcase
            write_blank_color(phase_color);
            queue_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        $display("Covered %0d put and %0d read transactions (%0d off screen)",
                 n_puts, n_reads, n_off_reads);
        $display("with %0d scrolls and %0d line wraps over %0d blank attribute settings",
                 n_scrolls, n_wraps, PHASES);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
